@@ sv/gpwf_pkg.sv @@
// Package for the weighted GNSS position filter: codes, fixed constants,
// the window control struct and the cosine table builder.
// No dependencies.
package gpwf_pkg;

    // Result codes
    localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
    localparam logic [1:0] VERDICT_LOW_Q   = 2'd1;
    localparam logic [1:0] VERDICT_OUTLIER = 2'd2;
    localparam logic [1:0] VERDICT_CLEARED = 2'd3;

    // Register indexes
    localparam logic REG_REJECT_DIST = 1'b0;
    localparam logic REG_MIN_SATS    = 1'b1;

    // Serial arithmetic operations
    typedef logic t_op;
    localparam t_op OP_MUL = 1'b0;
    localparam t_op OP_DIV = 1'b1;

    // Scale constants
    localparam logic [31:0] M_PER_DEG_LAT = 32'd111132;
    localparam logic [31:0] M_PER_DEG_LON = 32'd111319;
    localparam logic [31:0] DY_DIVISOR    = 32'd100000;
    localparam logic [31:0] DX_DIVISOR    = 32'd3276800000;
    localparam logic [31:0] LAT_LIMIT     = 32'd900000000;
    localparam logic [31:0] LAT_HALF      = 32'd450000000;
    localparam logic [63:0] DIST_SAT      = 64'h0000_0000_8000_0000;
    localparam logic [22:0] CM_PER_M      = 23'd100;

    // Series constants for the cosine table, Q30
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint SERIES_DIVS [7] = '{182, 132, 90, 56, 30, 12, 2};

    typedef struct packed {
        logic wr;
        logic sum_clr;
        logic sum_en;
    } t_win_ctrl;

    // Cosine of an angle given in Q30 radians, result in Q1.15.
    // Used only to build the constant table.
    function automatic logic [15:0] cos_from_x(input longint x);
        longint x2;
        longint t;
        x2 = x * x / Q30_ONE;
        t  = Q30_ONE;
        for (int k = 0; k < 7; k++) begin
            t = Q30_ONE - (x2 * t / Q30_ONE) / SERIES_DIVS[k];
        end
        if (t < 0) begin
            t = 0;
        end
        return 16'((t * 32768 + Q30_ONE / 2) / Q30_ONE);
    endfunction

endpackage

@@ sv/gnss_position_weighted_filter.sv @@
// Top level of the weighted GNSS position filter: sequencer, cosine table,
// held position and output register. Depends on gpwf_pkg, gpwf_window and
// gpwf_serial_unit.
//
//  Channel | Handshake                  | Contents
//  --------+----------------------------+-----------------------------------
//  in      | i_in_valid / o_in_ready    | command or one fix
//  out     | o_out_valid / i_out_ready  | verdict, held position, time, fill
//  cfg     | i_cfg_we                   | reject distance, minimum satellites
//
// A clear or a low-quality fix goes straight from idle to the emit state. An accepted
// first point is written to the window, summed and divided twice; the sum runs over
// fill entries, fill being the points in the window once the fix is written. A later
// point first passes the distance test of six multiplies and three divides, and an
// outlier goes from it to the emit state. Each multiply is 32 steps and each divide 64
// steps of the one bit-serial unit that every step shares.
// Reset is synchronous and active low; it empties the window and restores
// the register defaults. The input is taken only while the sequencer is
// idle; a result waits in the output register, and a new transfer is taken
// meanwhile, its own result held back until the register frees.
module gnss_position_weighted_filter #(
    parameter int WINDOW_DEPTH    = 5,
    parameter int COS_TABLE_DEPTH = 91
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic signed [30:0] i_fix_latitude,
    input  logic signed [31:0] i_fix_longitude,
    input  logic [6:0]         i_satellite_count,
    input  logic               i_gga_seen,
    input  logic [31:0]        i_fix_time,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_verdict,
    output logic signed [30:0] o_filtered_latitude,
    output logic signed [31:0] o_filtered_longitude,
    output logic [31:0]        o_position_time,
    output logic [2:0]         o_window_fill,
    output logic               o_first_in_session
);
    import gpwf_pkg::*;

    localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SW_MAX   = WINDOW_DEPTH * (WINDOW_DEPTH + 1) / 2;
    localparam int SW_W     = $clog2(SW_MAX + 1);
    localparam int SUM_W    = 32 + SW_W;
    localparam int CIDX_W   = $clog2(COS_TABLE_DEPTH);
    localparam int COS_SPAN = COS_TABLE_DEPTH - 1;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_IDX_MUL  = 4'd1;
    localparam logic [3:0] S_IDX_DIV  = 4'd2;
    localparam logic [3:0] S_DY_MUL   = 4'd3;
    localparam logic [3:0] S_DY_DIV   = 4'd4;
    localparam logic [3:0] S_DX_MUL1  = 4'd5;
    localparam logic [3:0] S_DX_MUL2  = 4'd6;
    localparam logic [3:0] S_DX_DIV   = 4'd7;
    localparam logic [3:0] S_SQ_X     = 4'd8;
    localparam logic [3:0] S_SQ_Y     = 4'd9;
    localparam logic [3:0] S_WRITE    = 4'd10;
    localparam logic [3:0] S_SUM      = 4'd11;
    localparam logic [3:0] S_DIV_LAT  = 4'd12;
    localparam logic [3:0] S_DIV_LON  = 4'd13;
    localparam logic [3:0] S_EMIT     = 4'd14;

    // Control state
    logic [3:0]        r_state, n_state;
    logic [15:0]       r_cfg_dist;
    logic [6:0]        r_cfg_sats;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_session, n_session;
    logic signed [30:0] r_held_lat, n_held_lat;
    logic signed [31:0] r_held_lon, n_held_lon;
    logic [31:0]       r_held_time, n_held_time;
    logic              r_out_valid, n_out_valid;
    logic              r_start, n_start;

    // Working registers
    t_op               r_uop, n_uop;
    logic [63:0]       r_ua, n_ua;
    logic [31:0]       r_ub, n_ub;
    logic signed [30:0] r_lat, n_lat;
    logic signed [31:0] r_lon, n_lon;
    logic [31:0]       r_time, n_time;
    logic [22:0]       r_lim, n_lim;
    logic [45:0]       r_lim2, n_lim2;
    logic [CIDX_W-1:0] r_cidx, n_cidx;
    logic [15:0]       r_cos, n_cos;
    logic [31:0]       r_dy, n_dy;
    logic [63:0]       r_sq, n_sq;
    logic [FILL_W-1:0] r_cnt, n_cnt;
    logic [SW_W-1:0]   r_sw, n_sw;
    logic [1:0]        r_verdict, n_verdict;
    logic              r_first, n_first;

    // Output register
    logic [1:0]        r_out_verdict;
    logic signed [30:0] r_out_lat;
    logic signed [31:0] r_out_lon;
    logic [31:0]       r_out_time;
    logic [2:0]        r_out_fill;
    logic              r_out_first;
    logic              w_load_out;

    // Datapath nets
    logic              w_in_xfer;
    t_win_ctrl         w_win_ctrl;
    logic signed [SUM_W-1:0] w_sum_lat;
    logic signed [SUM_W-1:0] w_sum_lon;
    logic [SUM_W-1:0]  w_mag_lat;
    logic [SUM_W-1:0]  w_mag_lon;
    logic              w_u_done;
    logic [63:0]       w_u_res;
    logic [30:0]       w_alat;
    logic [30:0]       w_alat_sat;
    logic signed [31:0] w_dlat;
    logic [31:0]       w_dlat_abs;
    logic signed [32:0] w_dlon;
    logic [32:0]       w_dlon_abs;
    logic [31:0]       w_dx_sat;
    logic [63:0]       w_dist2;
    logic [45:0]       w_lim_sq;
    logic [15:0]       w_cos_rom [COS_TABLE_DEPTH];

    // Cosine of the mean latitude, built at elaboration from the series.
    for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_cos
        localparam longint X = longint'(g) * HALF_PI_Q30 / COS_SPAN;
        assign w_cos_rom[g] = cos_from_x(X);
    end

    function automatic logic [31:0] sat_dist(input logic [63:0] v);
        return (v > DIST_SAT) ? DIST_SAT[31:0] : v[31:0];
    endfunction

    gpwf_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .FILL_W       (FILL_W),
        .IDX_W        (IDX_W),
        .SUM_W        (SUM_W)
    ) u_window (
        .i_clk     (i_clk),
        .i_ctrl    (w_win_ctrl),
        .i_fill    (r_fill),
        .i_rd_idx  (r_cnt[IDX_W-1:0]),
        .i_weight  (r_cnt + FILL_W'(1)),
        .i_lat     (r_lat),
        .i_lon     (r_lon),
        .o_sum_lat (w_sum_lat),
        .o_sum_lon (w_sum_lon)
    );

    gpwf_serial_unit u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_op     (r_uop),
        .i_a      (r_ua),
        .i_b      (r_ub),
        .o_done   (w_u_done),
        .o_result (w_u_res)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;

    // Distances are taken from the held mean, which is always the weighted
    // mean of the current window.
    assign w_alat     = r_held_lat[30] ? 31'(-r_held_lat) : 31'(r_held_lat);
    assign w_alat_sat = (w_alat > LAT_LIMIT[30:0]) ? LAT_LIMIT[30:0] : w_alat;
    assign w_dlat     = 32'(r_lat) - 32'(r_held_lat);
    assign w_dlat_abs = w_dlat[31] ? 32'(-w_dlat) : 32'(w_dlat);
    assign w_dlon     = 33'(r_lon) - 33'(r_held_lon);
    assign w_dlon_abs = w_dlon[32] ? 33'(-w_dlon) : 33'(w_dlon);
    assign w_dx_sat   = sat_dist(w_u_res);
    assign w_dist2    = r_sq + w_u_res;
    assign w_lim_sq   = {23'd0, r_lim} * {23'd0, r_lim};
    assign w_mag_lat  = w_sum_lat[SUM_W-1] ? SUM_W'(-w_sum_lat) : SUM_W'(w_sum_lat);
    assign w_mag_lon  = w_sum_lon[SUM_W-1] ? SUM_W'(-w_sum_lon) : SUM_W'(w_sum_lon);
    assign w_load_out = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_session   = r_session;
        n_held_lat  = r_held_lat;
        n_held_lon  = r_held_lon;
        n_held_time = r_held_time;
        n_out_valid = r_out_valid && !i_out_ready;
        n_start     = 1'b0;
        n_uop       = r_uop;
        n_ua        = r_ua;
        n_ub        = r_ub;
        n_lat       = r_lat;
        n_lon       = r_lon;
        n_time      = r_time;
        n_lim       = r_lim;
        n_lim2      = r_lim2;
        n_cidx      = r_cidx;
        n_cos       = r_cos;
        n_dy        = r_dy;
        n_sq        = r_sq;
        n_cnt       = r_cnt;
        n_sw        = r_sw;
        n_verdict   = r_verdict;
        n_first     = r_first;
        w_win_ctrl  = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_lat   = i_fix_latitude;
                    n_lon   = i_fix_longitude;
                    n_time  = i_fix_time;
                    n_lim   = 23'(r_cfg_dist) * CM_PER_M;
                    n_first = 1'b0;
                    if (i_command) begin
                        n_fill    = '0;
                        n_session = 1'b0;
                        n_verdict = VERDICT_CLEARED;
                        n_state   = S_EMIT;
                    end else if (!i_gga_seen || (i_satellite_count < r_cfg_sats)) begin
                        n_verdict = VERDICT_LOW_Q;
                        n_state   = S_EMIT;
                    end else if (r_fill == '0) begin
                        n_state = S_WRITE;
                    end else begin
                        // Table index: scaled mean latitude, rounded half up.
                        n_start = 1'b1;
                        n_uop   = OP_MUL;
                        n_ua    = 64'(w_alat_sat);
                        n_ub    = 32'(COS_SPAN);
                        n_state = S_IDX_MUL;
                    end
                end
            end
            S_IDX_MUL: begin
                n_lim2 = w_lim_sq;
                if (w_u_done) begin
                    n_start = 1'b1;
                    n_uop   = OP_DIV;
                    n_ua    = w_u_res + 64'(LAT_HALF);
                    n_ub    = LAT_LIMIT;
                    n_state = S_IDX_DIV;
                end
            end
            S_IDX_DIV: begin
                if (w_u_done) begin
                    n_cidx  = w_u_res[CIDX_W-1:0];
                    n_start = 1'b1;
                    n_uop   = OP_MUL;
                    n_ua    = 64'(w_dlat_abs);
                    n_ub    = M_PER_DEG_LAT;
                    n_state = S_DY_MUL;
                end
            end
            S_DY_MUL: begin
                n_cos = w_cos_rom[r_cidx];
                if (w_u_done) begin
                    n_start = 1'b1;
                    n_uop   = OP_DIV;
                    n_ua    = w_u_res;
                    n_ub    = DY_DIVISOR;
                    n_state = S_DY_DIV;
                end
            end
            S_DY_DIV: begin
                if (w_u_done) begin
                    n_dy    = sat_dist(w_u_res);
                    n_start = 1'b1;
                    n_uop   = OP_MUL;
                    n_ua    = 64'(w_dlon_abs);
                    n_ub    = M_PER_DEG_LON;
                    n_state = S_DX_MUL1;
                end
            end
            S_DX_MUL1: begin
                if (w_u_done) begin
                    n_start = 1'b1;
                    n_uop   = OP_MUL;
                    n_ua    = w_u_res;
                    n_ub    = 32'(r_cos);
                    n_state = S_DX_MUL2;
                end
            end
            S_DX_MUL2: begin
                if (w_u_done) begin
                    n_start = 1'b1;
                    n_uop   = OP_DIV;
                    n_ua    = w_u_res;
                    n_ub    = DX_DIVISOR;
                    n_state = S_DX_DIV;
                end
            end
            S_DX_DIV: begin
                if (w_u_done) begin
                    n_start = 1'b1;
                    n_uop   = OP_MUL;
                    n_ua    = 64'(w_dx_sat);
                    n_ub    = w_dx_sat;
                    n_state = S_SQ_X;
                end
            end
            S_SQ_X: begin
                if (w_u_done) begin
                    n_sq    = w_u_res;
                    n_start = 1'b1;
                    n_uop   = OP_MUL;
                    n_ua    = 64'(r_dy);
                    n_ub    = r_dy;
                    n_state = S_SQ_Y;
                end
            end
            S_SQ_Y: begin
                if (w_u_done) begin
                    if (w_dist2 > 64'(r_lim2)) begin
                        n_verdict = VERDICT_OUTLIER;
                        n_state   = S_EMIT;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                w_win_ctrl.wr      = 1'b1;
                w_win_ctrl.sum_clr = 1'b1;
                if (r_fill < FILL_W'(WINDOW_DEPTH)) begin
                    n_fill = r_fill + FILL_W'(1);
                end
                n_cnt   = '0;
                n_sw    = '0;
                n_state = S_SUM;
            end
            S_SUM: begin
                // One window entry per cycle, weight = position + 1.
                if (r_cnt < r_fill) begin
                    w_win_ctrl.sum_en = 1'b1;
                    n_sw  = r_sw + SW_W'(r_cnt) + SW_W'(1);
                    n_cnt = r_cnt + FILL_W'(1);
                end else begin
                    n_start = 1'b1;
                    n_uop   = OP_DIV;
                    n_ua    = 64'(w_mag_lat) + 64'(r_sw >> 1);
                    n_ub    = 32'(r_sw);
                    n_state = S_DIV_LAT;
                end
            end
            S_DIV_LAT: begin
                if (w_u_done) begin
                    n_held_lat = w_sum_lat[SUM_W-1] ? 31'(~w_u_res[30:0] + 31'd1)
                                                    : w_u_res[30:0];
                    n_start = 1'b1;
                    n_uop   = OP_DIV;
                    n_ua    = 64'(w_mag_lon) + 64'(r_sw >> 1);
                    n_ub    = 32'(r_sw);
                    n_state = S_DIV_LON;
                end
            end
            S_DIV_LON: begin
                if (w_u_done) begin
                    n_held_lon  = w_sum_lon[SUM_W-1] ? 32'(~w_u_res[31:0] + 32'd1)
                                                     : w_u_res[31:0];
                    n_held_time = r_time;
                    n_first     = !r_session;
                    n_session   = 1'b1;
                    n_verdict   = VERDICT_ACCEPT;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_dist  <= 16'd10;
            r_cfg_sats  <= 7'd4;
            r_fill      <= '0;
            r_session   <= 1'b0;
            r_held_lat  <= '0;
            r_held_lon  <= '0;
            r_held_time <= '0;
            r_out_valid <= 1'b0;
            r_start     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_session   <= n_session;
            r_held_lat  <= n_held_lat;
            r_held_lon  <= n_held_lon;
            r_held_time <= n_held_time;
            r_out_valid <= n_out_valid;
            r_start     <= n_start;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_REJECT_DIST: r_cfg_dist <= i_cfg_data;
                    REG_MIN_SATS:    r_cfg_sats <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working and output registers
    always_ff @(posedge i_clk) begin
        r_uop     <= n_uop;
        r_ua      <= n_ua;
        r_ub      <= n_ub;
        r_lat     <= n_lat;
        r_lon     <= n_lon;
        r_time    <= n_time;
        r_lim     <= n_lim;
        r_lim2    <= n_lim2;
        r_cidx    <= n_cidx;
        r_cos     <= n_cos;
        r_dy      <= n_dy;
        r_sq      <= n_sq;
        r_cnt     <= n_cnt;
        r_sw      <= n_sw;
        r_verdict <= n_verdict;
        r_first   <= n_first;
        if (w_load_out) begin
            r_out_verdict <= r_verdict;
            r_out_lat     <= r_held_lat;
            r_out_lon     <= r_held_lon;
            r_out_time    <= r_held_time;
            r_out_fill    <= 3'(r_fill);
            r_out_first   <= r_first;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_verdict            = r_out_verdict;
    assign o_filtered_latitude  = r_out_lat;
    assign o_filtered_longitude = r_out_lon;
    assign o_position_time      = r_out_time;
    assign o_window_fill        = r_out_fill;
    assign o_first_in_session   = r_out_first;

endmodule

@@ sv/gpwf_serial_unit.sv @@
// Shared bit-serial arithmetic unit: shift-add multiply (32 steps) and
// restoring divide (64 steps). Depends on gpwf_pkg.
module gpwf_serial_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  gpwf_pkg::t_op  i_op,
    input  logic [63:0]    i_a,
    input  logic [31:0]    i_b,
    output logic           o_done,
    output logic [63:0]    o_result
);
    import gpwf_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_op         r_op;
    logic [5:0]  r_cnt;
    logic [63:0] r_a;
    logic [31:0] r_b;
    logic [63:0] r_acc;
    logic [31:0] r_rem;

    logic [32:0] w_shift;
    logic        w_ge;
    logic        w_last;

    assign w_shift = {r_rem, r_a[63]};
    assign w_ge    = w_shift >= {1'b0, r_b};
    assign w_last  = (r_op == OP_MUL) ? (r_cnt == 6'd31) : (r_cnt == 6'd63);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_cnt <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_op == OP_MUL) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= {r_a[62:0], 1'b0};
                r_b <= {1'b0, r_b[31:1]};
            end else begin
                r_rem <= w_ge ? 32'(w_shift - {1'b0, r_b}) : w_shift[31:0];
                r_a   <= {r_a[62:0], w_ge};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == OP_DIV) ? r_a : r_acc;

endmodule

@@ sv/gpwf_window.sv @@
// Point window: latitude and longitude stores that fill and then roll,
// plus the weighted-sum accumulators. Depends on gpwf_pkg.
module gpwf_window #(
    parameter int WINDOW_DEPTH = 5,
    parameter int FILL_W       = 3,
    parameter int IDX_W        = 3,
    parameter int SUM_W        = 38
) (
    input  logic                     i_clk,
    input  gpwf_pkg::t_win_ctrl      i_ctrl,
    input  logic [FILL_W-1:0]        i_fill,
    input  logic [IDX_W-1:0]         i_rd_idx,
    input  logic [FILL_W-1:0]        i_weight,
    input  logic signed [30:0]       i_lat,
    input  logic signed [31:0]       i_lon,
    output logic signed [SUM_W-1:0]  o_sum_lat,
    output logic signed [SUM_W-1:0]  o_sum_lon
);
    import gpwf_pkg::*;

    logic signed [30:0] r_lat [WINDOW_DEPTH];
    logic signed [31:0] r_lon [WINDOW_DEPTH];
    logic signed [SUM_W-1:0] r_sum_lat;
    logic signed [SUM_W-1:0] r_sum_lon;

    logic signed [FILL_W+31:0] w_prod_lat;
    logic signed [FILL_W+32:0] w_prod_lon;

    assign w_prod_lat = $signed({1'b0, i_weight}) * r_lat[i_rd_idx];
    assign w_prod_lon = $signed({1'b0, i_weight}) * r_lon[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            if (i_fill < FILL_W'(WINDOW_DEPTH)) begin
                r_lat[i_fill[IDX_W-1:0]] <= i_lat;
                r_lon[i_fill[IDX_W-1:0]] <= i_lon;
            end else begin
                for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                    r_lat[i] <= r_lat[i+1];
                    r_lon[i] <= r_lon[i+1];
                end
                r_lat[WINDOW_DEPTH-1] <= i_lat;
                r_lon[WINDOW_DEPTH-1] <= i_lon;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sum_clr) begin
            r_sum_lat <= '0;
            r_sum_lon <= '0;
        end else if (i_ctrl.sum_en) begin
            r_sum_lat <= r_sum_lat + SUM_W'(w_prod_lat);
            r_sum_lon <= r_sum_lon + SUM_W'(w_prod_lon);
        end
    end

    assign o_sum_lat = r_sum_lat;
    assign o_sum_lon = r_sum_lon;

endmodule
